[design/sle_pkg.sv]
// sle_pkg: shared types and constants for the sorted list engine.
// No dependencies; used by sle_cell and sorted_list_engine_top.
package sle_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INS  = 2'd0,
        OP_DEL  = 2'd1,
        OP_DUMP = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        C_HOLD = 2'd0,
        C_INS  = 2'd1,
        C_DEL  = 2'd2,
        C_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [VAL_W-1:0]  key;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [VAL_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [VAL_W-1:0]  entry_value;
        logic                     last;
    } t_res;

endpackage

[design/sle_cell.sv]
// sle_cell: one slot of the sorted chain; compares, shifts or rotates its value.
// Depends on sle_pkg.
module sle_cell (
    input  logic                              i_clk,
    input  sle_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_occ,
    input  logic                              i_lt_prev,
    input  logic signed [sle_pkg::VAL_W-1:0]  i_prev_val,
    input  logic signed [sle_pkg::VAL_W-1:0]  i_next_val,
    input  logic                              i_next_occ,
    input  logic signed [sle_pkg::VAL_W-1:0]  i_head_val,
    output logic signed [sle_pkg::VAL_W-1:0]  o_val,
    output logic                              o_lt,
    output logic                              o_hit
);

    logic signed [sle_pkg::VAL_W-1:0] r_val;
    logic signed [sle_pkg::VAL_W-1:0] n_val;

    assign o_val = r_val;
    assign o_lt  = i_occ && (r_val < i_ctl.key);
    // first slot not below the key, holding an equal value
    assign o_hit = i_occ && !o_lt && i_lt_prev && (r_val == i_ctl.key);

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            sle_pkg::C_INS: begin
                if (!o_lt) begin
                    n_val = i_lt_prev ? i_prev_val : i_ctl.key;
                end
                if (!o_lt && i_lt_prev) begin
                    n_val = i_ctl.key;
                end else if (!o_lt) begin
                    n_val = i_prev_val;
                end
            end
            sle_pkg::C_DEL: begin
                if (!o_lt) begin
                    n_val = i_next_val;
                end
            end
            sle_pkg::C_ROT: begin
                n_val = i_next_occ ? i_next_val : i_head_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[design/sorted_list_engine_top.sv]
// sorted_list_engine_top: sorted store built from a chain of sle_cell slots.
// Depends on sle_pkg and sle_cell.
//
//  channel   ports                    handshake
//  command   i_start, i_cmd           beat taken when i_start && !o_busy
//  result    o_strobe, o_result       beat valid for one cycle, no back-pressure
//
// Insert and delete: one beat per cycle while o_busy is low, result registered
// in the cycle after acceptance; all slots compare against the key in parallel
// and shift by one place. Dump: o_busy after acceptance while the chain rotates
// its occupied slots once, one entry per cycle out of slot 0; an empty list gives one STAT_EMPTY beat.
// Reset is synchronous; it clears the entry count, sequencer and result strobe only.
module sorted_list_engine_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  sle_pkg::t_req  i_cmd,
    output logic           o_strobe,
    output sle_pkg::t_res  o_result
);

    localparam int D = sle_pkg::DEPTH;

    sle_pkg::t_state     r_state, n_state;
    logic [sle_pkg::CNT_W-1:0] r_count, n_count;
    logic [sle_pkg::CNT_W-1:0] r_left, n_left;
    logic                r_strobe, n_strobe;
    sle_pkg::t_res       r_res, n_res;

    sle_pkg::t_cell_ctl  cell_ctl;
    logic signed [sle_pkg::VAL_W-1:0] vals [D];
    logic signed [sle_pkg::VAL_W-1:0] prev_vals [D];
    logic signed [sle_pkg::VAL_W-1:0] next_vals [D];
    logic [D-1:0]        occ;
    logic [D-1:0]        next_occ;
    logic [D-1:0]        lt;
    logic [D-1:0]        lt_prev;
    logic [D-1:0]        hit;

    logic                accept;
    logic                full;
    logic                found;
    sle_pkg::t_op        req_op;

    assign accept   = i_start && !o_busy;
    assign full     = (r_count == sle_pkg::CNT_W'(D));
    assign found    = |hit;
    assign req_op   = sle_pkg::t_op'(i_cmd.opcode);
    assign o_busy   = (r_state == sle_pkg::S_DUMP);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    for (genvar i = 0; i < D; i++) begin : g_cell
        assign occ[i] = (r_count > sle_pkg::CNT_W'(i));
        if (i == 0) begin : g_head
            assign prev_vals[i] = cell_ctl.key;
            assign lt_prev[i]   = 1'b1;
        end else begin : g_body
            assign prev_vals[i] = vals[i-1];
            assign lt_prev[i]   = lt[i-1];
        end
        if (i == D - 1) begin : g_tail
            assign next_vals[i] = vals[i];
            assign next_occ[i]  = 1'b0;
        end else begin : g_inner
            assign next_vals[i] = vals[i+1];
            assign next_occ[i]  = occ[i+1];
        end

        sle_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_occ      (occ[i]),
            .i_lt_prev  (lt_prev[i]),
            .i_prev_val (prev_vals[i]),
            .i_next_val (next_vals[i]),
            .i_next_occ (next_occ[i]),
            .i_head_val (vals[0]),
            .o_val      (vals[i]),
            .o_lt       (lt[i]),
            .o_hit      (hit[i])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sle_pkg::S_IDLE: begin
                if (accept && req_op == sle_pkg::OP_DUMP && r_count != '0) begin
                    n_state = sle_pkg::S_DUMP;
                end
            end
            sle_pkg::S_DUMP: begin
                if (r_left == sle_pkg::CNT_W'(1)) begin
                    n_state = sle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sle_pkg::S_IDLE;
            end
        endcase
    end

    // outputs, chain control and counters
    always_comb begin
        cell_ctl.op  = sle_pkg::C_HOLD;
        cell_ctl.key = i_cmd.value;
        n_count      = r_count;
        n_left       = r_left;
        n_strobe     = 1'b0;
        n_res        = r_res;
        case (r_state)
            sle_pkg::S_DUMP: begin
                cell_ctl.op       = sle_pkg::C_ROT;
                n_left            = r_left - sle_pkg::CNT_W'(1);
                n_strobe          = 1'b1;
                n_res.status      = sle_pkg::STAT_OK;
                n_res.entry_value = vals[0];
                n_res.last        = (r_left == sle_pkg::CNT_W'(1));
            end
            sle_pkg::S_IDLE: begin
                if (accept) begin
                    n_res.entry_value = i_cmd.value;
                    n_res.last        = 1'b1;
                    case (req_op)
                        sle_pkg::OP_INS: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_res.status = sle_pkg::STAT_FULL;
                            end else begin
                                cell_ctl.op  = sle_pkg::C_INS;
                                n_count      = r_count + sle_pkg::CNT_W'(1);
                                n_res.status = sle_pkg::STAT_OK;
                            end
                        end
                        sle_pkg::OP_DEL: begin
                            n_strobe = 1'b1;
                            if (found) begin
                                cell_ctl.op  = sle_pkg::C_DEL;
                                n_count      = r_count - sle_pkg::CNT_W'(1);
                                n_res.status = sle_pkg::STAT_OK;
                            end else begin
                                n_res.status = sle_pkg::STAT_NOTFOUND;
                            end
                        end
                        sle_pkg::OP_DUMP: begin
                            n_left = r_count;
                            if (r_count == '0) begin
                                n_strobe          = 1'b1;
                                n_res.status      = sle_pkg::STAT_EMPTY;
                                n_res.entry_value = '0;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sle_pkg::S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sle_pkg::CNT_W'(D))
        else $error("entry count beyond depth");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("more than one delete position");

    a_dump_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sle_pkg::S_DUMP) |=> o_strobe)
        else $error("dump cycle without result beat");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req_op == sle_pkg::OP_INS && !full)
        |=> (r_count == $past(r_count) + sle_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");
`endif

endmodule

[test/tb_sorted_list_engine_top.sv]
`timescale 1ns / 1ps
// tb_sorted_list_engine_top: self-checking bench for the sorted list engine.
// Depends on sle_pkg and sorted_list_engine_top; a shadow sorted list predicts
// every result beat, and a monitor checks the beats in order.
module tb_sorted_list_engine_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CMDS = 330;
    localparam int CALM_TAIL   = 40;
    localparam int MAX_REPORTS = 10;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    logic            o_busy;
    sle_pkg::t_req   i_cmd = '0;
    logic            o_strobe;
    sle_pkg::t_res   o_result;

    sorted_list_engine_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    int rst_cycles = 0;
    always @(posedge i_clk) begin
        if (rst_cycles < 3) begin
            rst_cycles <= rst_cycles + 1;
        end else begin
            i_rst_n <= 1'b1;
        end
    end

    sle_pkg::t_req                    cmd_queue[$];
    sle_pkg::t_res                    expected_results[$];
    logic signed [sle_pkg::VAL_W-1:0] shadow_vals[sle_pkg::DEPTH];
    int                               shadow_count = 0;
    logic signed [sle_pkg::VAL_W-1:0] insert_history[$];

    int n_accepted = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_ins_ok = 0, n_ins_full = 0, n_del_ok = 0, n_del_miss = 0;
    int n_dump = 0, n_dump_empty = 0, n_ignored = 0;

    task automatic predict_list_op(input sle_pkg::t_req req);
        logic signed [sle_pkg::VAL_W-1:0] key;
        sle_pkg::t_res                    r;
        int                               pos;
        int                               i;
        key = req.value;
        r.status = sle_pkg::STAT_OK;
        r.entry_value = key;
        r.last = 1'b1;
        case (req.opcode)
            sle_pkg::OP_INS: begin
                if (shadow_count >= sle_pkg::DEPTH) begin
                    r.status = sle_pkg::STAT_FULL;
                    n_ins_full++;
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_vals[pos] < key) pos++;
                    for (i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[pos] = key;
                    shadow_count++;
                    n_ins_ok++;
                end
                expected_results.push_back(r);
            end
            sle_pkg::OP_DEL: begin
                pos = 0;
                while (pos < shadow_count && shadow_vals[pos] != key) pos++;
                if (pos >= shadow_count) begin
                    r.status = sle_pkg::STAT_NOTFOUND;
                    n_del_miss++;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
                    shadow_count--;
                    n_del_ok++;
                end
                expected_results.push_back(r);
            end
            sle_pkg::OP_DUMP: begin
                if (shadow_count == 0) begin
                    r.status = sle_pkg::STAT_EMPTY;
                    r.entry_value = '0;
                    expected_results.push_back(r);
                    n_dump_empty++;
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        r.entry_value = shadow_vals[i];
                        r.last = (i + 1 == shadow_count);
                        expected_results.push_back(r);
                    end
                    n_dump++;
                end
            end
            default: n_ignored++;
        endcase
    endtask

    // driver: holds a beat while busy, random idle bursts except near the end
    int idle_left = 0;
    bit idle_enabled = 1'b1;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                predict_list_op(i_cmd);
                void'(cmd_queue.pop_front());
                n_accepted++;
                if (n_accepted % 25 == 0) idle_enabled = ($urandom_range(0, 2) != 0);
            end
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                i_start <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                i_start <= 1'b0;
            end else if (idle_enabled && cmd_queue.size() > CALM_TAIL
                         && $urandom_range(0, 3) == 0) begin
                idle_left = $urandom_range(0, 3);
                i_start <= 1'b0;
            end else begin
                i_start <= 1'b1;
                i_cmd <= cmd_queue[0];
            end
        end
    end

    sle_pkg::t_res exp_res;
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("unexpected beat: status %0d value %0d last %0d",
                             o_result.status, o_result.entry_value, o_result.last);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result.status !== exp_res.status
                    || o_result.entry_value !== exp_res.entry_value
                    || o_result.last !== exp_res.last) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display({"mismatch at beat %0d: expected status %0d ",
                                  "value %0d last %0d, got status %0d value %0d last %0d"},
                                 n_results, exp_res.status, exp_res.entry_value,
                                 exp_res.last, o_result.status,
                                 o_result.entry_value, o_result.last);
                end
            end
        end
    end

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d commands pending and %0d beats expected",
                     cmd_queue.size(), expected_results.size());
            $display("sorted_list_engine_top regression: fail");
            $finish;
        end
    end

    task automatic add_cmd(input sle_pkg::t_op op,
                           input logic signed [sle_pkg::VAL_W-1:0] val);
        sle_pkg::t_req req;
        req.opcode = op;
        req.value = val;
        cmd_queue.push_back(req);
        if (op == sle_pkg::OP_INS) begin
            insert_history.push_back(val);
            if (insert_history.size() > 64) void'(insert_history.pop_front());
        end
    endtask

    function automatic logic signed [sle_pkg::VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5) return 32'sh8000_0000;
        if (sel < 10) return 32'sh7FFF_FFFF;
        if (sel < 35) return $signed(32'($urandom_range(0, 15))) - 8;
        return $urandom;
    endfunction

    int        roll;
    int        n;
    bit        fill_phase;
    logic signed [sle_pkg::VAL_W-1:0] del_val;

    initial begin
        // directed: empty cases, extremes, duplicates, fill to full, full drop
        add_cmd(sle_pkg::OP_DUMP, $urandom);
        add_cmd(sle_pkg::OP_DEL, 32'sd5);
        add_cmd(sle_pkg::OP_INS, 32'sh7FFF_FFFF);
        add_cmd(sle_pkg::OP_INS, 32'sh8000_0000);
        add_cmd(sle_pkg::OP_INS, 32'sh7FFF_FFFF);
        add_cmd(sle_pkg::OP_DEL, 32'sh7FFF_FFFF);
        add_cmd(sle_pkg::OP_DEL, 32'sh8000_0000);
        add_cmd(sle_pkg::OP_NONE, $urandom);
        add_cmd(sle_pkg::OP_INS, 32'sd0);
        add_cmd(sle_pkg::OP_INS, -32'sd1);
        add_cmd(sle_pkg::OP_INS, 32'sd1);
        add_cmd(sle_pkg::OP_INS, 32'sd0);
        for (n = 0; n < 11; n++) add_cmd(sle_pkg::OP_INS, $urandom);
        add_cmd(sle_pkg::OP_INS, 32'sd3);
        add_cmd(sle_pkg::OP_DUMP, 32'sd0);

        for (n = 0; n < RANDOM_CMDS; n++) begin
            fill_phase = ((n / 32) % 2 == 0);
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                add_cmd(sle_pkg::OP_NONE, $urandom);
            end else if (roll < 13) begin
                add_cmd(sle_pkg::OP_DUMP, $urandom);
            end else if ($urandom_range(0, 99) < (fill_phase ? 85 : 15)) begin
                add_cmd(sle_pkg::OP_INS, pick_value());
            end else begin
                if (insert_history.size() > 0 && $urandom_range(0, 99) < 60)
                    del_val = insert_history[$urandom_range(0, insert_history.size() - 1)];
                else
                    del_val = pick_value();
                add_cmd(sle_pkg::OP_DEL, del_val);
            end
        end

        while (cmd_queue.size() != 0 || i_start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (sle_pkg::DEPTH + 4) @(posedge i_clk);

        $display("%0d commands: %0d inserts, %0d full drops, %0d deletes, %0d misses",
                 n_accepted, n_ins_ok, n_ins_full, n_del_ok, n_del_miss);
        $display("%0d dumps, %0d empty dumps, %0d ignored opcodes",
                 n_dump, n_dump_empty, n_ignored);
        $display("%0d beats checked, %0d mismatches", n_results, n_mismatch);
        if (n_mismatch == 0) begin
            $display("sorted_list_engine_top regression: pass");
        end else begin
            $display("sorted_list_engine_top regression: fail");
        end
        $finish;
    end

endmodule
